/* rtl/cau_pkg.sv */
// Shared constants and types of the complex arithmetic unit.
package cau_pkg;

  localparam int CAU_WORD_BITS = 32;
  localparam int CAU_FRAC_BITS = 16;

  // Operation codes
  typedef enum logic [2:0] {
    KIND_ADD  = 3'd0,
    KIND_SUB  = 3'd1,
    KIND_MUL  = 3'd2,
    KIND_DIV  = 3'd3,
    KIND_MAG  = 3'd4,
    KIND_SQRT = 3'd5
  } kind_e;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_DIV_ZERO = 2'd1;
  localparam logic [1:0] ST_SAT      = 2'd2;

endpackage

/* rtl/cau_if.sv */
// Valid/ready stream interfaces for operand and result words.
interface cau_in_if #(
  parameter int WORD_BITS = cau_pkg::CAU_WORD_BITS
);
  logic                        valid;
  logic                        ready;
  logic [2:0]                  kind;
  logic signed [WORD_BITS-1:0] a_real;
  logic signed [WORD_BITS-1:0] a_imag;
  logic signed [WORD_BITS-1:0] b_real;
  logic signed [WORD_BITS-1:0] b_imag;

  modport source (output valid, kind, a_real, a_imag, b_real, b_imag, input ready);
  modport sink   (input valid, kind, a_real, a_imag, b_real, b_imag, output ready);
endinterface

interface cau_out_if #(
  parameter int WORD_BITS = cau_pkg::CAU_WORD_BITS
);
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] r_real;
  logic signed [WORD_BITS-1:0] r_imag;
  logic [1:0]                  status;

  modport source (output valid, r_real, r_imag, status, input ready);
  modport sink   (input valid, r_real, r_imag, status, output ready);
endinterface

/* rtl/cau_sqrt_cell.sv */
// One cell of the integer square root chain: resolves one root bit per cycle while en_i is high.
module cau_sqrt_cell #(
  parameter int WORD_BITS = cau_pkg::CAU_WORD_BITS,
  parameter int TAG_BITS  = 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic [2*WORD_BITS-1:0]   x_i,
  input  logic [WORD_BITS+1:0]     rem_i,
  input  logic [WORD_BITS-1:0]     root_i,
  input  logic [TAG_BITS-1:0]      tag_i,
  output logic [2*WORD_BITS-1:0]   x_o,
  output logic [WORD_BITS+1:0]     rem_o,
  output logic [WORD_BITS-1:0]     root_o,
  output logic [TAG_BITS-1:0]      tag_o
);
  localparam int W  = WORD_BITS;
  localparam int DW = 2 * W;

  logic [W+3:0]  sh;
  logic [W+3:0]  trial;
  logic [W+3:0]  diff;
  logic          take;
  logic [DW-1:0] x_d;
  logic [W+1:0]  rem_d;
  logic [W-1:0]  root_d;

  // bring down the next two radicand bits and try the next root bit
  always_comb begin
    sh     = {rem_i, x_i[DW-1 -: 2]};
    trial  = {2'b00, root_i, 2'b01};
    diff   = sh - trial;
    take   = (sh >= trial);
    rem_d  = take ? diff[W+1:0] : sh[W+1:0];
    root_d = {root_i[W-2:0], take};
    x_d    = {x_i[DW-3:0], 2'b00};
  end

  // data registers
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_o    <= x_d;
      rem_o  <= rem_d;
      root_o <= root_d;
    end
  end

  // tag carries the valid bit, so it is reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_o <= '0;
    end else if (en_i) begin
      tag_o <= tag_i;
    end
  end

endmodule

/* rtl/cau_div_cell.sv */
// One cell of the restoring divider chain: one quotient bit per cycle while en_i is high.
module cau_div_cell #(
  parameter int WORD_BITS = cau_pkg::CAU_WORD_BITS,
  parameter int FRAC_BITS = cau_pkg::CAU_FRAC_BITS,
  parameter int TAG_BITS  = 1
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic [2*WORD_BITS+FRAC_BITS-1:0]    n_i,
  input  logic [2*WORD_BITS-1:0]              r_i,
  input  logic [WORD_BITS+1:0]                q_i,
  input  logic                                ovf_i,
  input  logic [2*WORD_BITS-1:0]              den_i,
  input  logic [TAG_BITS-1:0]                 tag_i,
  output logic [2*WORD_BITS+FRAC_BITS-1:0]    n_o,
  output logic [2*WORD_BITS-1:0]              r_o,
  output logic [WORD_BITS+1:0]                q_o,
  output logic                                ovf_o,
  output logic [2*WORD_BITS-1:0]              den_o,
  output logic [TAG_BITS-1:0]                 tag_o
);
  localparam int W  = WORD_BITS;
  localparam int DW = 2 * W;
  localparam int NB = DW + FRAC_BITS;
  localparam int QW = W + 2;
  localparam logic [QW-1:0] CAPQ = {{(QW-1){1'b0}}, 1'b1} << (W - 1);

  logic [DW:0]   sh;
  logic [DW:0]   diff;
  logic          take;
  logic [DW-1:0] r_d;
  logic [QW-1:0] q_d;
  logic          ovf_d;
  logic [NB-1:0] n_d;

  // shift in the next dividend bit, subtract when it fits
  always_comb begin
    sh    = {r_i, n_i[NB-1]};
    diff  = sh - {1'b0, den_i};
    take  = (sh >= {1'b0, den_i});
    r_d   = take ? diff[DW-1:0] : sh[DW-1:0];
    q_d   = {q_i[QW-2:0], take};
    // once past the word range the quotient only grows: keep a sticky flag
    ovf_d = ovf_i | (q_d > CAPQ);
    n_d   = {n_i[NB-2:0], 1'b0};
  end

  // data registers
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_o   <= n_d;
      r_o   <= r_d;
      q_o   <= q_d;
      ovf_o <= ovf_d;
      den_o <= den_i;
    end
  end

  // tag carries the valid bit, so it is reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_o <= '0;
    end else if (en_i) begin
      tag_o <= tag_i;
    end
  end

endmodule

/* rtl/complex_arithmetic_unit_core.sv */
// Complex arithmetic unit: add, subtract, multiply, divide, magnitude and square root on
// signed fixed-point complex words (Q16.16 with the default parameters). Fully pipelined: one
// word is accepted every cycle while the output word is not held. Each word passes through
// the operand/product stage, two WORD_BITS-long square root cell chains (one root bit
// per cell), a 2*WORD_BITS+FRAC_BITS-long divider cell chain (one quotient bit per cell) and
// the saturating output register. When the output word is held, the whole chain holds.
module complex_arithmetic_unit_core #(
  parameter int WORD_BITS = cau_pkg::CAU_WORD_BITS,
  parameter int FRAC_BITS = cau_pkg::CAU_FRAC_BITS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cau_in_if.sink    in_i,
  cau_out_if.source out_o
);
  import cau_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int DW = 2 * W;
  localparam int NB = DW + F;
  localparam int QW = W + 2;
  localparam logic [DW-1:0] CAP = {{(DW-1){1'b0}}, 1'b1} << (W - 1);

  typedef struct packed {
    logic         neg;
    logic [W-1:0] mag;
  } op_t;

  typedef struct packed {
    logic          neg;
    logic [DW-1:0] mag;
  } sv_t;

  typedef enum logic [1:0] {
    SEL_DIRECT,
    SEL_DIVA,
    SEL_DIVB
  } sel_e;

  // tag through the first root chain
  typedef struct packed {
    logic          valid;
    kind_e         kind;
    op_t           ar;
    op_t           ai;
    sv_t           re;
    sv_t           im;
    logic [DW-1:0] den;
    logic          dz;
  } a_t;

  // tag through root chain B1
  typedef struct packed {
    logic          valid;
    kind_e         kind;
    sv_t           re;
    sv_t           im;
    logic [DW-1:0] den;
    logic          dz;
    logic          zero;
    logic          negreal;
  } b_t;

  // tag through divider chain A
  typedef struct packed {
    logic valid;
    sv_t  re;
    logic dz3;
    logic re_div;
    sel_e im_sel;
  } c_t;

  localparam int AT = $bits(a_t);
  localparam int BT = $bits(b_t);
  localparam int OT = $bits(op_t);
  localparam int CT = $bits(c_t);
  localparam int ST = $bits(sv_t);

  function automatic op_t dec(input logic [W-1:0] v);
    op_t o;
    o.neg = v[W-1];
    o.mag = v[W-1] ? (~v + 1'b1) : v;
    return o;
  endfunction

  function automatic sv_t ext(input op_t o);
    sv_t s;
    s.neg = o.neg;
    s.mag = {{W{1'b0}}, o.mag};
    return s;
  endfunction

  function automatic sv_t neg_sv(input sv_t a);
    sv_t s;
    s     = a;
    s.neg = ~a.neg;
    return s;
  endfunction

  function automatic sv_t add_sv(input sv_t a, input sv_t b);
    sv_t s;
    if (a.neg == b.neg) begin
      s.neg = a.neg;
      s.mag = a.mag + b.mag;
    end else if (a.mag >= b.mag) begin
      s.neg = a.neg;
      s.mag = a.mag - b.mag;
    end else begin
      s.neg = b.neg;
      s.mag = b.mag - a.mag;
    end
    return s;
  endfunction

  function automatic logic [W-1:0] sat_pack(input sv_t v, output logic sat);
    logic [DW-1:0] m;
    logic [DW-1:0] nm;
    logic [W-1:0]  r;
    sat = 1'b0;
    m   = v.mag;
    if (v.neg) begin
      if (m > CAP) begin
        m   = CAP;
        sat = 1'b1;
      end
      nm = ~m + 1'b1;
      r  = nm[W-1:0];
    end else begin
      if (m > CAP - 1'b1) begin
        m   = CAP - 1'b1;
        sat = 1'b1;
      end
      r = m[W-1:0];
    end
    return r;
  endfunction

  logic en;
  logic out_valid_q;

  assign en       = !out_valid_q || out_o.ready;
  assign in_i.ready = en;

  // ---------------------------------------------------------------- operand stage
  logic          s0_valid_q;
  kind_e         s0_kind_q;
  op_t           s0_ar_q, s0_ai_q, s0_br_q, s0_bi_q;
  logic [DW-1:0] s0_prr_q, s0_pii_q, s0_pri_q, s0_pir_q;
  logic [DW-1:0] s0_pbr_q, s0_pbi_q, s0_par_q, s0_pai_q;
  op_t           ar_d, ai_d, br_d, bi_d;

  always_comb begin
    ar_d = dec(in_i.a_real);
    ai_d = dec(in_i.a_imag);
    br_d = dec(in_i.b_real);
    bi_d = dec(in_i.b_imag);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (en) begin
      s0_valid_q <= in_i.valid;
    end
  end

  // magnitude products, one multiplier per product
  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_kind_q <= kind_e'(in_i.kind);
      s0_ar_q   <= ar_d;
      s0_ai_q   <= ai_d;
      s0_br_q   <= br_d;
      s0_bi_q   <= bi_d;
      s0_prr_q  <= ar_d.mag * br_d.mag;
      s0_pii_q  <= ai_d.mag * bi_d.mag;
      s0_pri_q  <= ar_d.mag * bi_d.mag;
      s0_pir_q  <= ai_d.mag * br_d.mag;
      s0_pbr_q  <= br_d.mag * br_d.mag;
      s0_pbi_q  <= bi_d.mag * bi_d.mag;
      s0_par_q  <= ar_d.mag * ar_d.mag;
      s0_pai_q  <= ai_d.mag * ai_d.mag;
    end
  end

  // ---------------------------------------------------------------- combine products
  a_t            a_d;
  logic [DW-1:0] xa_d;
  sv_t           t_rr, t_ii, t_ri, t_ir;

  always_comb begin
    t_rr = {s0_ar_q.neg ^ s0_br_q.neg, s0_prr_q};
    t_ii = {s0_ai_q.neg ^ s0_bi_q.neg, s0_pii_q};
    t_ri = {s0_ar_q.neg ^ s0_bi_q.neg, s0_pri_q};
    t_ir = {s0_ai_q.neg ^ s0_br_q.neg, s0_pir_q};
    a_d       = '0;
    a_d.valid = s0_valid_q;
    a_d.kind  = s0_kind_q;
    a_d.ar    = s0_ar_q;
    a_d.ai    = s0_ai_q;
    a_d.den   = s0_pbr_q + s0_pbi_q;
    a_d.dz    = (a_d.den == '0);
    xa_d      = s0_par_q + s0_pai_q;
    unique case (s0_kind_q)
      KIND_ADD: begin
        a_d.re = add_sv(ext(s0_ar_q), ext(s0_br_q));
        a_d.im = add_sv(ext(s0_ai_q), ext(s0_bi_q));
      end
      KIND_SUB: begin
        a_d.re = add_sv(ext(s0_ar_q), neg_sv(ext(s0_br_q)));
        a_d.im = add_sv(ext(s0_ai_q), neg_sv(ext(s0_bi_q)));
      end
      KIND_MUL: begin
        a_d.re     = add_sv(t_rr, neg_sv(t_ii));
        a_d.im     = add_sv(t_ri, t_ir);
        a_d.re.mag = a_d.re.mag >> F;
        a_d.im.mag = a_d.im.mag >> F;
      end
      KIND_DIV: begin
        a_d.re = add_sv(t_rr, t_ii);
        a_d.im = add_sv(t_ir, neg_sv(t_ri));
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------- root chain A: |a|
  logic [DW-1:0] sa_x    [0:W];
  logic [W+1:0]  sa_rem  [0:W];
  logic [W-1:0]  sa_root [0:W];
  logic [AT-1:0] sa_tag  [0:W];

  assign sa_x[0]    = xa_d;
  assign sa_rem[0]  = '0;
  assign sa_root[0] = '0;
  assign sa_tag[0]  = a_d;

  for (genvar i = 0; i < W; i++) begin : g_sqa
    cau_sqrt_cell #(.WORD_BITS(W), .TAG_BITS(AT)) u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .x_i(sa_x[i]), .rem_i(sa_rem[i]), .root_i(sa_root[i]), .tag_i(sa_tag[i]),
      .x_o(sa_x[i+1]), .rem_o(sa_rem[i+1]), .root_o(sa_root[i+1]), .tag_o(sa_tag[i+1])
    );
  end

  // ---------------------------------------------------------------- root chain B setup
  a_t            a_q;
  logic [W-1:0]  m_q;
  b_t            b_d;
  logic [DW-1:0] xb1_d, xb2_d;
  logic [W:0]    msum;
  logic [W:0]    mdif;

  always_comb begin
    a_q         = a_t'(sa_tag[W]);
    m_q         = sa_root[W];
    msum        = {1'b0, m_q} + {1'b0, a_q.ar.mag};
    mdif        = {1'b0, m_q} - {1'b0, a_q.ar.mag};
    b_d         = '0;
    b_d.valid   = a_q.valid;
    b_d.kind    = a_q.kind;
    b_d.re      = a_q.re;
    b_d.im      = a_q.im;
    b_d.den     = a_q.den;
    b_d.dz      = a_q.dz;
    xb1_d       = '0;
    xb2_d       = '0;
    unique case (a_q.kind)
      KIND_MAG: begin
        b_d.re = {1'b0, {W{1'b0}}, m_q};
      end
      KIND_SQRT: begin
        b_d.zero    = (a_q.ar.mag == '0) && (a_q.ai.mag == '0);
        b_d.negreal = (a_q.ai.mag == '0) && a_q.ar.neg;
        if (b_d.negreal) begin
          xb1_d = {{W{1'b0}}, a_q.ar.mag} << F;
        end else if (a_q.ar.neg) begin
          xb1_d = {{(DW-W-1){1'b0}}, mdif} << (F - 1);
          xb2_d = {{(DW-W-1){1'b0}}, msum} << (F - 1);
        end else begin
          xb1_d = {{(DW-W-1){1'b0}}, msum} << (F - 1);
          xb2_d = {{(DW-W-1){1'b0}}, mdif} << (F - 1);
        end
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------- root chains B1, B2
  logic [DW-1:0] sb1_x    [0:W];
  logic [W+1:0]  sb1_rem  [0:W];
  logic [W-1:0]  sb1_root [0:W];
  logic [BT-1:0] sb1_tag  [0:W];
  logic [DW-1:0] sb2_x    [0:W];
  logic [W+1:0]  sb2_rem  [0:W];
  logic [W-1:0]  sb2_root [0:W];
  logic [OT-1:0] sb2_tag  [0:W];

  assign sb1_x[0]    = xb1_d;
  assign sb1_rem[0]  = '0;
  assign sb1_root[0] = '0;
  assign sb1_tag[0]  = b_d;
  assign sb2_x[0]    = xb2_d;
  assign sb2_rem[0]  = '0;
  assign sb2_root[0] = '0;
  assign sb2_tag[0]  = a_q.ai;

  for (genvar i = 0; i < W; i++) begin : g_sqb
    cau_sqrt_cell #(.WORD_BITS(W), .TAG_BITS(BT)) u_cell1 (
      .clk_i, .rst_ni, .en_i(en),
      .x_i(sb1_x[i]), .rem_i(sb1_rem[i]), .root_i(sb1_root[i]), .tag_i(sb1_tag[i]),
      .x_o(sb1_x[i+1]), .rem_o(sb1_rem[i+1]), .root_o(sb1_root[i+1]),
      .tag_o(sb1_tag[i+1])
    );
    cau_sqrt_cell #(.WORD_BITS(W), .TAG_BITS(OT)) u_cell2 (
      .clk_i, .rst_ni, .en_i(en),
      .x_i(sb2_x[i]), .rem_i(sb2_rem[i]), .root_i(sb2_root[i]), .tag_i(sb2_tag[i]),
      .x_o(sb2_x[i+1]), .rem_o(sb2_rem[i+1]), .root_o(sb2_root[i+1]),
      .tag_o(sb2_tag[i+1])
    );
  end

  // ---------------------------------------------------------------- divider setup
  b_t            b_q;
  op_t           ai_q;
  logic [W-1:0]  r1_q, r2_q;
  c_t            c_d;
  sv_t           im_d;
  logic [DW-1:0] num_a, num_b, den_a, den_b;

  always_comb begin
    b_q       = b_t'(sb1_tag[W]);
    ai_q      = op_t'(sb2_tag[W]);
    r1_q      = sb1_root[W];
    r2_q      = sb2_root[W];
    c_d       = '0;
    c_d.valid = b_q.valid;
    c_d.re    = b_q.re;
    c_d.im_sel = SEL_DIRECT;
    im_d      = b_q.im;
    num_a     = '0;
    num_b     = '0;
    den_a     = '0;
    den_b     = '0;
    unique case (b_q.kind)
      KIND_DIV: begin
        if (b_q.dz) begin
          c_d.dz3 = 1'b1;
          c_d.re  = '0;
          im_d    = '0;
        end else begin
          c_d.re_div = 1'b1;
          c_d.im_sel = SEL_DIVB;
          num_a      = b_q.re.mag;
          num_b      = b_q.im.mag;
          den_a      = b_q.den;
          den_b      = b_q.den;
        end
      end
      KIND_SQRT: begin
        c_d.re = '0;
        im_d   = '0;
        if (b_q.zero) begin
          // root of zero stays zero
        end else if (b_q.negreal) begin
          im_d.mag = {{W{1'b0}}, r1_q};
        end else begin
          c_d.re.mag = {{W{1'b0}}, r1_q};
          im_d.neg   = ai_q.neg;
          if (r1_q != '0) begin
            c_d.im_sel = SEL_DIVA;
            num_a      = {{W{1'b0}}, ai_q.mag};
            den_a      = {{W{1'b0}}, r1_q} << 1;
          end else begin
            // real part vanished: imaginary part from the second root
            im_d.mag = {{W{1'b0}}, r2_q};
          end
        end
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------- divider chains
  logic [NB-1:0] da_n   [0:NB];
  logic [DW-1:0] da_r   [0:NB];
  logic [QW-1:0] da_q   [0:NB];
  logic          da_ovf [0:NB];
  logic [DW-1:0] da_den [0:NB];
  logic [CT-1:0] da_tag [0:NB];
  logic [NB-1:0] db_n   [0:NB];
  logic [DW-1:0] db_r   [0:NB];
  logic [QW-1:0] db_q   [0:NB];
  logic          db_ovf [0:NB];
  logic [DW-1:0] db_den [0:NB];
  logic [ST-1:0] db_tag [0:NB];

  assign da_n[0]   = {num_a, {F{1'b0}}};
  assign da_r[0]   = '0;
  assign da_q[0]   = '0;
  assign da_ovf[0] = 1'b0;
  assign da_den[0] = den_a;
  assign da_tag[0] = c_d;
  assign db_n[0]   = {num_b, {F{1'b0}}};
  assign db_r[0]   = '0;
  assign db_q[0]   = '0;
  assign db_ovf[0] = 1'b0;
  assign db_den[0] = den_b;
  assign db_tag[0] = im_d;

  for (genvar i = 0; i < NB; i++) begin : g_div
    cau_div_cell #(.WORD_BITS(W), .FRAC_BITS(F), .TAG_BITS(CT)) u_cell_a (
      .clk_i, .rst_ni, .en_i(en),
      .n_i(da_n[i]), .r_i(da_r[i]), .q_i(da_q[i]), .ovf_i(da_ovf[i]),
      .den_i(da_den[i]), .tag_i(da_tag[i]),
      .n_o(da_n[i+1]), .r_o(da_r[i+1]), .q_o(da_q[i+1]), .ovf_o(da_ovf[i+1]),
      .den_o(da_den[i+1]), .tag_o(da_tag[i+1])
    );
    cau_div_cell #(.WORD_BITS(W), .FRAC_BITS(F), .TAG_BITS(ST)) u_cell_b (
      .clk_i, .rst_ni, .en_i(en),
      .n_i(db_n[i]), .r_i(db_r[i]), .q_i(db_q[i]), .ovf_i(db_ovf[i]),
      .den_i(db_den[i]), .tag_i(db_tag[i]),
      .n_o(db_n[i+1]), .r_o(db_r[i+1]), .q_o(db_q[i+1]), .ovf_o(db_ovf[i+1]),
      .den_o(db_den[i+1]), .tag_o(db_tag[i+1])
    );
  end

  // ---------------------------------------------------------------- select and saturate
  c_t            c_q;
  sv_t           re_f, im_f;
  logic [DW-1:0] qa, qb;
  logic [W-1:0]  r_real_d, r_imag_d;
  logic          sat_re, sat_im;
  logic [1:0]    status_d;

  always_comb begin
    c_q  = c_t'(da_tag[NB]);
    qa   = da_ovf[NB] ? (CAP + 1'b1) : {{(DW-QW){1'b0}}, da_q[NB]};
    qb   = db_ovf[NB] ? (CAP + 1'b1) : {{(DW-QW){1'b0}}, db_q[NB]};
    re_f = c_q.re;
    im_f = sv_t'(db_tag[NB]);
    if (c_q.re_div) begin
      re_f.mag = qa;
    end
    case (c_q.im_sel)
      SEL_DIVA: im_f.mag = qa;
      SEL_DIVB: im_f.mag = qb;
      default:  begin end
    endcase
    r_real_d = sat_pack(re_f, sat_re);
    r_imag_d = sat_pack(im_f, sat_im);
    if (c_q.dz3) begin
      status_d = ST_DIV_ZERO;
    end else if (sat_re || sat_im) begin
      status_d = ST_SAT;
    end else begin
      status_d = ST_OK;
    end
  end

  // output word register
  logic [W-1:0] r_real_q, r_imag_q;
  logic [1:0]   status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= c_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r_real_q <= r_real_d;
      r_imag_q <= r_imag_d;
      status_q <= status_d;
    end
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.r_real = r_real_q;
  assign out_o.r_imag = r_imag_q;
  assign out_o.status = status_q;

endmodule

/* rtl/cau_checker.sv */
// Port-level assertions for the complex arithmetic unit, bound to the top level.
module cau_checker #(
  parameter int WORD_BITS = cau_pkg::CAU_WORD_BITS
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic signed [WORD_BITS-1:0] r_real_i,
  input logic signed [WORD_BITS-1:0] r_imag_i,
  input logic [1:0]                  status_i
);
  import cau_pkg::*;

  localparam logic [WORD_BITS-1:0] WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic [WORD_BITS-1:0] WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  // a held result keeps its valid, real part and status
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(r_real_i) && $stable(status_i))
    else $error("result word changed while stalled");

  // the unit takes a word whenever the output side is free
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_i || out_ready_i) |-> in_ready_i)
    else $error("input not ready with free output");

  // division by zero gives a zero result
  a_dz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == ST_DIV_ZERO |-> r_real_i == '0 && r_imag_i == '0)
    else $error("division by zero with nonzero result");

  // saturation leaves a part at a range limit
  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == ST_SAT |->
      (r_real_i == WMAX || r_real_i == WMIN || r_imag_i == WMAX || r_imag_i == WMIN))
    else $error("saturated status without a clamped part");

  // no undefined status code while input and output are both valid
  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && in_valid_i |-> status_i != 2'd3)
    else $error("undefined status code");

endmodule

bind complex_arithmetic_unit_core cau_checker #(.WORD_BITS(WORD_BITS)) u_cau_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .r_real_i    (out_o.r_real),
  .r_imag_i    (out_o.r_imag),
  .status_i    (out_o.status)
);
